[design/melody_player_fsm_assert.svh]
// ----------------------------------------------------------------------------
// Melody player assertion macros
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef MELODY_PLAYER_FSM_ASSERT_SVH
`define MELODY_PLAYER_FSM_ASSERT_SVH
`ifndef SYNTHESIS
// General property check, disabled while reset is asserted
`define MPF_ASSERT(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
        else $error("melody player: property check failed");
// At most one bit of the vector is set
`define MPF_ONEHOT0(lbl, clk_s, rstn_s, vec) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) $onehot0(vec)) \
        else $error("melody player: one-hot check failed");
`else
`define MPF_ASSERT(lbl, clk_s, rstn_s, prop)
`define MPF_ONEHOT0(lbl, clk_s, rstn_s, vec)
`endif
`endif

[design/mpf_pkg.sv]
// ----------------------------------------------------------------------------
// mpf_pkg
// Types, codes and widths shared by the melody player sequencer.
// ----------------------------------------------------------------------------
package mpf_pkg;

    // Default note table depth
    localparam int MELODY_DEPTH_DEF = 256;

    // Field widths
    localparam int KIND_W     = 2;
    localparam int ACT_W      = 2;
    localparam int SLOT_W     = 8;
    localparam int FREQ_W     = 16;
    localparam int NDUR_W     = 16;
    localparam int DUR_W      = 24;
    localparam int SPEED_W    = 16;
    localparam int POS_W      = 9;
    localparam int STATE_W    = 3;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;
    localparam int NOTE_W     = FREQ_W + NDUR_W;

    localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

    // Player state, as reported in player_state
    typedef enum logic [STATE_W-1:0] {
        PS_WAIT_START  = 3'd0,
        PS_WAIT_NOTE   = 3'd1,
        PS_PLAY_NOTE   = 3'd2,
        PS_PAUSE       = 3'd3,
        PS_WAIT_MELODY = 3'd4
    } ps_t;

    // User action
    typedef enum logic [ACT_W-1:0] {
        ACT_STOP  = 2'd0,
        ACT_PLAY  = 2'd1,
        ACT_PAUSE = 2'd2
    } act_t;

    // Input item kind
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 2'd0,
        KIND_ACTION = 2'd1,
        KIND_LOAD   = 2'd2
    } kind_t;

    // Configuration register index
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MELODY_LENGTH = 2'd0,
        CFG_MELODY_LOADED = 2'd1,
        CFG_SPEED         = 2'd2
    } cfg_idx_t;

    // Item sequencer
    typedef enum logic [1:0] {
        CTL_IDLE = 2'd0,
        CTL_RD   = 2'd1,
        CTL_DIV  = 2'd2,
        CTL_FIN  = 2'd3
    } ctl_t;

    // Divider request and response
    typedef struct packed {
        logic               start;
        logic [DUR_W-1:0]   dividend;
        logic [SPEED_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DUR_W-1:0] quotient;
    } div_rsp_t;

endpackage

[design/melody_player_fsm.sv]
// ----------------------------------------------------------------------------
// melody_player_fsm
// Melody player sequencer: note table in a synchronous RAM, five-state
// player, note duration scaled by an iterative divider.
//
//  channel   dir  handshake              payload
//  s_axis    in   s_axis_tvalid/tready   tuser: kind; tdata: item fields
//  m_axis    out  m_axis_tvalid/tready   tdata: result fields
//  cfg       in   cfg_we                 cfg_index, cfg_wdata
//
// Load, action and non-starting tick items: accept (CTL_IDLE), result
// (CTL_FIN). A tick that starts a note also passes CTL_RD (RAM read) and
// CTL_DIV, the 24-step restoring divider (no steps at zero speed).
// One item is in work at a time; the next is accepted while the result
// waits in the output register. No clearing pass after reset.
// ----------------------------------------------------------------------------
`include "melody_player_fsm_assert.svh"

module melody_player_fsm #(
    parameter int MELODY_DEPTH = mpf_pkg::MELODY_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // slave side
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [0] note_timeout, [2:1] action, [10:3] note_slot,
    // [26:11] note_frequency, [42:27] note_duration
    input  logic [mpf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] kind
    input  logic [mpf_pkg::KIND_W-1:0]      s_axis_tuser,
    // master side
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] start_note, [16:1] tone_frequency, [40:17] tone_duration,
    // [41] stop_tone, [44:42] player_state, [46:45] action_now, [47] active
    output logic [mpf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // configuration
    input  logic                            cfg_we,
    input  logic [mpf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mpf_pkg::CFG_W-1:0]       cfg_wdata
);

    localparam int AW  = $clog2(MELODY_DEPTH);
    localparam int PW  = mpf_pkg::POS_W;
    localparam int FW  = mpf_pkg::FREQ_W;
    localparam int NDW = mpf_pkg::NDUR_W;
    localparam int DW  = mpf_pkg::DUR_W;

    // Input fields
    logic             in_timeout;
    logic [1:0]       in_action;
    logic [7:0]       in_slot;
    logic [FW-1:0]    in_freq;
    logic [NDW-1:0]   in_dur;

    assign in_timeout = s_axis_tdata[0];
    assign in_action  = s_axis_tdata[2:1];
    assign in_slot    = s_axis_tdata[10:3];
    assign in_freq    = s_axis_tdata[26:11];
    assign in_dur     = s_axis_tdata[42:27];

    // Registers
    mpf_pkg::ctl_t  ctl_reg, ctl_next;
    mpf_pkg::ps_t   player_reg, player_next;
    mpf_pkg::act_t  mode_reg, mode_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic [PW-1:0]  len_reg;
    logic           loaded_reg;
    logic [mpf_pkg::SPEED_W-1:0] speed_reg;

    logic           res_start_reg, res_start_next;
    logic           res_stop_reg, res_stop_next;
    logic [FW-1:0]  res_freq_reg, res_freq_next;
    logic [DW-1:0]  res_dur_reg, res_dur_next;
    logic           rd_zero_reg, rd_zero_next;

    logic                              m_valid_reg, m_valid_next;
    logic [mpf_pkg::OUT_DATA_W-1:0]    m_data_reg, m_data_next;

    // Sequencer outputs
    logic in_ready;
    logic in_xfer;
    logic div_start;
    logic out_load;

    // Player decision
    logic           start_c;
    logic           stop_c;
    logic [PW-1:0]  idx_c;
    logic           wr_en_c;
    logic [31:0]    idx_w;
    logic [31:0]    slot_w;

    // RAM and divider
    logic [mpf_pkg::NOTE_W-1:0] rd_data;
    logic [FW-1:0]              rd_freq;
    logic [NDW-1:0]             rd_dur;
    mpf_pkg::div_req_t          div_req;
    mpf_pkg::div_rsp_t          div_rsp;

    logic active_c;

    assign in_xfer = s_axis_tvalid & in_ready;
    assign idx_w   = 32'(idx_c);
    assign slot_w  = 32'(in_slot);

    // Player step, taken at the input transfer
    always_comb
    begin
        player_next = player_reg;
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        start_c     = 1'b0;
        stop_c      = 1'b0;
        idx_c       = '0;
        wr_en_c     = 1'b0;
        if (in_xfer)
        begin
            case (mpf_pkg::kind_t'(s_axis_tuser))
                mpf_pkg::KIND_TICK:
                begin
                    case (player_reg)
                        mpf_pkg::PS_WAIT_NOTE:
                        begin
                            if (in_timeout)
                            begin
                                stop_c      = 1'b1;
                                player_next = mpf_pkg::PS_PLAY_NOTE;
                            end
                        end
                        mpf_pkg::PS_PLAY_NOTE:
                        begin
                            if ((pos_reg < len_reg) && (mode_reg == mpf_pkg::ACT_PLAY))
                            begin
                                start_c     = 1'b1;
                                idx_c       = pos_reg;
                                pos_next    = pos_reg + 1'b1;
                                player_next = mpf_pkg::PS_WAIT_NOTE;
                            end
                            else if (pos_reg >= len_reg)
                            begin
                                // end of melody
                                stop_c      = 1'b1;
                                pos_next    = '0;
                                mode_next   = mpf_pkg::ACT_STOP;
                                player_next = mpf_pkg::PS_WAIT_MELODY;
                            end
                            else if (mode_reg == mpf_pkg::ACT_STOP)
                            begin
                                stop_c      = 1'b1;
                                pos_next    = '0;
                                player_next = mpf_pkg::PS_WAIT_START;
                            end
                            else if (mode_reg == mpf_pkg::ACT_PAUSE)
                            begin
                                stop_c      = 1'b1;
                                player_next = mpf_pkg::PS_PAUSE;
                            end
                        end
                        mpf_pkg::PS_PAUSE:
                        begin
                            if (mode_reg == mpf_pkg::ACT_PLAY)
                            begin
                                player_next = mpf_pkg::PS_PLAY_NOTE;
                            end
                        end
                        default:
                        begin
                            // wait start and wait melody: restart from entry zero
                            if (player_reg != mpf_pkg::PS_WAIT_MELODY)
                            begin
                                player_next = mpf_pkg::PS_WAIT_START;
                            end
                            if (loaded_reg && (mode_reg == mpf_pkg::ACT_PLAY))
                            begin
                                start_c     = 1'b1;
                                idx_c       = '0;
                                pos_next    = pos_reg + 1'b1;
                                player_next = mpf_pkg::PS_WAIT_NOTE;
                            end
                        end
                    endcase
                end
                mpf_pkg::KIND_ACTION:
                begin
                    case (mpf_pkg::act_t'(in_action))
                        mpf_pkg::ACT_STOP:
                        begin
                            mode_next = mpf_pkg::ACT_STOP;
                            pos_next  = '0;
                        end
                        mpf_pkg::ACT_PLAY:
                        begin
                            mode_next = mpf_pkg::ACT_PLAY;
                        end
                        mpf_pkg::ACT_PAUSE:
                        begin
                            mode_next = mpf_pkg::ACT_PAUSE;
                        end
                        default:
                        begin
                            // unknown action kept out
                        end
                    endcase
                end
                mpf_pkg::KIND_LOAD:
                begin
                    wr_en_c = (slot_w < MELODY_DEPTH);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result payload
    assign rd_freq = rd_zero_reg ? '0 : rd_data[FW-1:0];
    assign rd_dur  = rd_zero_reg ? '0 : rd_data[mpf_pkg::NOTE_W-1:FW];

    always_comb
    begin
        res_start_next = res_start_reg;
        res_stop_next  = res_stop_reg;
        res_freq_next  = res_freq_reg;
        res_dur_next   = res_dur_reg;
        rd_zero_next   = rd_zero_reg;
        if (in_xfer)
        begin
            res_start_next = start_c;
            res_stop_next  = stop_c;
            res_freq_next  = '0;
            res_dur_next   = '0;
            rd_zero_next   = (idx_w >= MELODY_DEPTH);
        end
        else if (ctl_reg == mpf_pkg::CTL_RD)
        begin
            res_freq_next = rd_freq;
        end
        else if ((ctl_reg == mpf_pkg::CTL_DIV) && div_rsp.done)
        begin
            res_dur_next = div_rsp.quotient;
        end
    end

    // Sequencer next state
    always_comb
    begin
        ctl_next = ctl_reg;
        case (ctl_reg)
            mpf_pkg::CTL_IDLE:
            begin
                if (in_xfer)
                begin
                    ctl_next = start_c ? mpf_pkg::CTL_RD : mpf_pkg::CTL_FIN;
                end
            end
            mpf_pkg::CTL_RD:
            begin
                ctl_next = mpf_pkg::CTL_DIV;
            end
            mpf_pkg::CTL_DIV:
            begin
                if (div_rsp.done)
                begin
                    ctl_next = mpf_pkg::CTL_FIN;
                end
            end
            mpf_pkg::CTL_FIN:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    ctl_next = mpf_pkg::CTL_IDLE;
                end
            end
            default:
            begin
                ctl_next = mpf_pkg::CTL_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (ctl_reg)
            mpf_pkg::CTL_IDLE:
            begin
                in_ready = 1'b1;
            end
            mpf_pkg::CTL_RD:
            begin
                div_start = 1'b1;
            end
            mpf_pkg::CTL_DIV:
            begin
            end
            mpf_pkg::CTL_FIN:
            begin
                out_load = !m_valid_reg || m_axis_tready;
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    assign active_c = (mode_reg == mpf_pkg::ACT_PLAY) || (mode_reg == mpf_pkg::ACT_PAUSE);

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {active_c, mode_reg, player_reg, res_stop_reg,
                            res_dur_reg, res_freq_reg, res_start_reg};
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    // Control and player state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= mpf_pkg::CTL_IDLE;
            player_reg    <= mpf_pkg::PS_WAIT_START;
            mode_reg      <= mpf_pkg::ACT_STOP;
            pos_reg       <= '0;
            m_valid_reg   <= 1'b0;
            res_start_reg <= 1'b0;
            res_stop_reg  <= 1'b0;
        end
        else
        begin
            ctl_reg       <= ctl_next;
            player_reg    <= player_next;
            mode_reg      <= mode_next;
            pos_reg       <= pos_next;
            m_valid_reg   <= m_valid_next;
            res_start_reg <= res_start_next;
            res_stop_reg  <= res_stop_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            loaded_reg <= 1'b0;
            speed_reg  <= 16'd256;
        end
        else if (cfg_we)
        begin
            case (mpf_pkg::cfg_idx_t'(cfg_index))
                mpf_pkg::CFG_MELODY_LENGTH: len_reg    <= cfg_wdata[PW-1:0];
                mpf_pkg::CFG_MELODY_LOADED: loaded_reg <= cfg_wdata[0];
                mpf_pkg::CFG_SPEED:         speed_reg  <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        res_freq_reg <= res_freq_next;
        res_dur_reg  <= res_dur_next;
        rd_zero_reg  <= rd_zero_next;
        m_data_reg   <= m_data_next;
    end

    // Note table; loads and reads belong to different items, so never overlap
    mpf_note_ram #(
        .DEPTH (MELODY_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en_c),
        .wr_addr (slot_w[AW-1:0]),
        .wr_data ({in_dur, in_freq}),
        .rd_en   (in_xfer & start_c),
        .rd_addr (idx_w[AW-1:0]),
        .rd_data (rd_data)
    );

    // Duration scaling: (duration << 8) / speed
    assign div_req.start    = div_start;
    assign div_req.dividend = {rd_dur, 8'h00};
    assign div_req.divisor  = speed_reg;

    mpf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Assertions
    `MPF_ASSERT(a_done_in_div, clk, rst_n, div_rsp.done |-> ctl_reg == mpf_pkg::CTL_DIV)
    `MPF_ASSERT(a_rd_to_div, clk, rst_n,
                ctl_reg == mpf_pkg::CTL_RD |=> ctl_reg == mpf_pkg::CTL_DIV)
    `MPF_ASSERT(a_start_wait_note, clk, rst_n,
                (ctl_reg == mpf_pkg::CTL_FIN && res_start_reg) |->
                player_reg == mpf_pkg::PS_WAIT_NOTE)
    `MPF_ONEHOT0(a_start_stop_excl, clk, rst_n, {res_start_reg, res_stop_reg})

endmodule

[design/mpf_note_ram.sv]
// ----------------------------------------------------------------------------
// mpf_note_ram
// Note table: one write port, one read port, registered read data.
// Each entry holds {duration, frequency}.
// ----------------------------------------------------------------------------
module mpf_note_ram #(
    parameter int DEPTH = mpf_pkg::MELODY_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [mpf_pkg::NOTE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [mpf_pkg::NOTE_W-1:0] rd_data
);

    logic [mpf_pkg::NOTE_W-1:0] mem_reg [DEPTH];
    logic [mpf_pkg::NOTE_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/mpf_div.sv]
// ----------------------------------------------------------------------------
// mpf_div
// Restoring divider, one quotient bit per cycle. A zero divisor answers
// all ones the cycle after start. done pulses for one cycle; quotient holds.
// ----------------------------------------------------------------------------
module mpf_div (
    input  logic              clk,
    input  logic              rst_n,
    input  mpf_pkg::div_req_t req,
    output mpf_pkg::div_rsp_t rsp
);

    localparam int DW = mpf_pkg::DUR_W;
    localparam int SW = mpf_pkg::SPEED_W;
    localparam int CW = $clog2(DW);
    localparam logic [CW-1:0] LAST_STEP = CW'(DW - 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [SW-1:0] dvs_reg, dvs_next;

    logic [SW:0] trial;
    logic [SW:0] diff;
    logic        fits;

    // One restoring step
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            dvs_next = req.divisor;
            rem_next = '0;
            cnt_next = '0;
            if (req.divisor == '0)
            begin
                // zero speed saturates
                quo_next  = mpf_pkg::DUR_MAX;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                quo_next  = req.dividend;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[SW-1:0] : trial[SW-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
